### src/rpcq_pkg.sv
// Shared constants, codes, types and the cost table of the paced command queue.
package rpcq_pkg;

   localparam int QUEUE_DEPTH = 10;
   localparam int KIND_COUNT  = 14;

   localparam int OPCODE_W = 3;
   localparam int KIND_W   = 4;
   localparam int HANDLE_W = 32;
   localparam int SLOT_W   = 6;
   localparam int TIME_W   = 48;
   localparam int FREQ_W   = 16;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 7;
   localparam int COST_W   = 29;
   localparam int PROD_W   = TIME_W + FREQ_W;

   localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int TRACK_W = $clog2(KIND_COUNT);
   localparam int SUM_W   = SLOT_W + 1;

   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 48;

   localparam logic [FREQ_W-1:0] FREQ_DEFAULT = FREQ_W'(100);

   localparam logic [KIND_W-1:0] KIND_INVENTORY = KIND_W'(4);
   localparam logic [KIND_W-1:0] KIND_TAKE      = KIND_W'(5);

   localparam logic [OPCODE_W-1:0] OP_ADD_BACK  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_FRONT = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP       = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REPLACE   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_PEEK      = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_COOLDOWN  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   // controller -> datapath strobes, one per phase
   typedef struct packed {
      logic load;
      logic read;
      logic mult;
      logic exec;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_sts_type;

   // cost of a kind in microsecond-scaled ticks (cost * 1e6)
   function automatic logic [COST_W-1:0] cost_us(input logic [KIND_W-1:0] kind);
      logic [COST_W-1:0] c;
      case (kind) inside
         4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10: c = COST_W'(7000000);
         4'd4:    c = COST_W'(1000000);
         4'd8:    c = COST_W'(300000000);
         4'd9:    c = COST_W'(42000000);
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

### src/rpcq_ctrl.sv
// Phase sequencer of the paced command queue: accept, read, multiply, execute.
module rpcq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  rpcq_pkg::dp_sts_type   dp_sts,
   output rpcq_pkg::dp_cmd_type   dp_cmd
);
   import rpcq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_MULT = 4'b0100,
      S_EXEC = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.load = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            dp_cmd.read = 1'b1;
            state_in    = S_MULT;
         end
         S_MULT: begin
            dp_cmd.mult = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            // hold here while the previous item still sits in the output register
            if (dp_sts.out_free) begin
               dp_cmd.exec = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_READ))
      else $error("accepted item did not start a read phase");
`endif

endmodule

### src/rpcq_datapath.sv
// Ring store, per-kind issue times, cooldown arithmetic and result register.
module rpcq_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rpcq_pkg::dp_cmd_type            dp_cmd,
   output rpcq_pkg::dp_sts_type            dp_sts,
   input  logic [rpcq_pkg::OPCODE_W-1:0]   in_opcode,
   input  logic [rpcq_pkg::KIND_W-1:0]     in_kind,
   input  logic [rpcq_pkg::HANDLE_W-1:0]   in_handle,
   input  logic [rpcq_pkg::SLOT_W-1:0]     in_slot,
   input  logic [rpcq_pkg::TIME_W-1:0]     in_time,
   input  logic                            csr_wen,
   input  logic [rpcq_pkg::FREQ_W-1:0]     csr_wdata,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [rpcq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rpcq_pkg::KIND_W-1:0]     rsp_kind,
   output logic [rpcq_pkg::HANDLE_W-1:0]   rsp_handle,
   output logic [rpcq_pkg::OCC_W-1:0]      rsp_occupancy
);
   import rpcq_pkg::*;

   // latched item
   logic [OPCODE_W-1:0] op_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [TIME_W-1:0]   now_ff;

   // stores
   entry_type           entry_mem_ff [QUEUE_DEPTH];
   logic [TIME_W-1:0]   last_time_mem_ff [KIND_COUNT];

   // queue state
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [KIND_COUNT-1:0] seen_ff, seen_in;
   logic [TIME_W-1:0]     release_ff, release_in;
   logic [FREQ_W-1:0]     freq_ff;

   // read phase
   logic [SLOT_W-1:0]  pos;
   logic [SUM_W-1:0]   slot_sum, slot_wrap;
   logic [IDX_W-1:0]   dec_head, addr_in, addr_ff;
   logic [TRACK_W-1:0] track_in, track_ff;
   entry_type          rd_entry_ff;
   logic [TIME_W-1:0]  rd_time_ff;

   // multiply phase
   logic [TIME_W-1:0]  since, elapsed;
   logic [KIND_W-1:0]  cost_kind;
   logic [PROD_W-1:0]  prod_in, prod_ff;
   logic               behind_ff;
   logic [COST_W-1:0]  cost_ff;

   // execute phase
   logic                waited, cool_ok, slot_ok, ent_we, time_we;
   logic [STATUS_W-1:0] status_in;
   logic [KIND_W-1:0]   okind_in;
   logic [HANDLE_W-1:0] ohandle_in;
   logic                rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         op_ff     <= in_opcode;
         kind_ff   <= in_kind;
         handle_ff <= in_handle;
         slot_ff   <= in_slot;
         now_ff    <= in_time;
      end
   end

   // slot address: head + position, modulo depth when the sum is below twice the depth
   always_comb begin
      pos       = (op_ff == OP_ADD_BACK) ? SLOT_W'(count_ff) : slot_ff;
      slot_sum  = SUM_W'(head_ff) + SUM_W'(pos);
      slot_wrap = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ? slot_sum - SUM_W'(QUEUE_DEPTH) : slot_sum;
      dec_head  = (head_ff == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_ff - 1'b1;
      case (op_ff)
         OP_ADD_FRONT: addr_in = dec_head;
         OP_POP:       addr_in = head_ff;
         default:      addr_in = IDX_W'(slot_wrap);
      endcase
      track_in = ((KIND_W + 1)'(kind_ff) < (KIND_W + 1)'(KIND_COUNT)) ?
                 TRACK_W'(kind_ff) : TRACK_W'(KIND_COUNT - 1);
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.read) begin
         addr_ff     <= addr_in;
         track_ff    <= track_in;
         rd_entry_ff <= entry_mem_ff[addr_in];
      end
      if (dp_cmd.exec && ent_we) begin
         entry_mem_ff[addr_ff] <= '{kind: kind_ff, handle: handle_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.read) begin
         rd_time_ff <= last_time_mem_ff[track_in];
      end
      if (dp_cmd.exec && time_we) begin
         last_time_mem_ff[track_ff] <= now_ff;
      end
   end

   // elapsed * f against cost * 1e6
   always_comb begin
      since     = (op_ff == OP_POP) ? release_ff : rd_time_ff;
      cost_kind = (op_ff == OP_POP) ? rd_entry_ff.kind : kind_ff;
      elapsed   = now_ff - since;
      prod_in   = PROD_W'(elapsed) * PROD_W'(freq_ff);
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.mult) begin
         prod_ff   <= prod_in;
         behind_ff <= (now_ff < since);
         cost_ff   <= cost_us(cost_kind);
      end
   end

   always_comb begin
      waited  = !behind_ff && (prod_ff >= PROD_W'(cost_ff));
      cool_ok = (kind_ff == KIND_INVENTORY) || (kind_ff == KIND_TAKE) ||
                !seen_ff[track_ff] || waited;
      slot_ok = OCC_W'(slot_ff) < OCC_W'(count_ff);

      status_in  = ST_OK;
      okind_in   = '0;
      ohandle_in = '0;
      head_in    = head_ff;
      count_in   = count_ff;
      seen_in    = seen_ff;
      release_in = release_ff;
      ent_we     = 1'b0;
      time_we    = 1'b0;

      case (op_ff)
         OP_ADD_BACK, OP_ADD_FRONT: begin
            if (!cool_ok) begin
               status_in = ST_COOLDOWN;
            end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               ent_we            = 1'b1;
               time_we           = 1'b1;
               seen_in[track_ff] = 1'b1;
               count_in          = count_ff + 1'b1;
               if (op_ff == OP_ADD_FRONT) begin
                  head_in = addr_ff;
               end
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (!waited) begin
               status_in = ST_NOT_READY;
            end else begin
               okind_in   = rd_entry_ff.kind;
               ohandle_in = rd_entry_ff.handle;
               head_in    = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_in   = count_ff - 1'b1;
               release_in = now_ff;
            end
         end
         OP_REPLACE: begin
            if (!slot_ok) begin
               status_in = ST_BAD_INDEX;
            end else begin
               ent_we            = 1'b1;
               time_we           = 1'b1;
               seen_in[track_ff] = 1'b1;
            end
         end
         OP_PEEK: begin
            if (!slot_ok) begin
               status_in = ST_BAD_INDEX;
            end else begin
               okind_in   = rd_entry_ff.kind;
               ohandle_in = rd_entry_ff.handle;
            end
         end
         OP_CLEAR: begin
            head_in    = '0;
            count_in   = '0;
            seen_in    = '0;
            release_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         seen_ff    <= '0;
         release_ff <= '0;
      end else if (dp_cmd.exec) begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         seen_ff    <= seen_in;
         release_ff <= release_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_DEFAULT;
      end else if (csr_wen) begin
         freq_ff <= (csr_wdata == '0) ? FREQ_DEFAULT : csr_wdata;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         rsp_status    <= status_in;
         rsp_kind      <= okind_in;
         rsp_handle    <= ohandle_in;
         rsp_occupancy <= OCC_W'(count_in);
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign dp_sts.out_free = !rsp_valid_ff || rsp_tready;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff < IDX_W'(QUEUE_DEPTH))
      else $error("head pointer outside ring");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.exec |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while held");
`endif

endmodule

### src/rate_paced_command_queue_top.sv
// Top level of the rate-paced command queue: field unpacking and unit wiring.
//
// Request channel (req_*): one command per item, opcode in tuser; push back/front,
// pop when ready, replace and peek at a position, clear. Every item gives exactly
// one result item on the rsp_* channel: status in tuser, the popped or peeked
// entry and the occupancy after the command in tdata.
// csr_wen/csr_wdata write the tick frequency (a zero write stores 100); write
// it only while no command is in flight.
// Sequencing: an accepted item walks the read, multiply and execute phases, and its result
// is registered at execute; the sequencer walks accept, read, multiply, execute and takes
// no new item until the last one has executed. The cooldown check is one 48x16 multiply
// between the read of the stored issue time and the compare against cost * 1e6.
// req_tready is high only while the sequencer waits for an item. A stalled
// receiver holds the result register; the next item is accepted and processed up
// to its execute phase, which waits until the held result is taken.
// Reset (synchronous, active high) empties the queue, clears all issue history
// and the last release time, and sets the tick frequency to 100.
module rate_paced_command_queue_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // command_kind, command_handle, slot_index, time_us, zero pad
   input  logic [rpcq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // opcode
   input  logic [rpcq_pkg::OPCODE_W-1:0]        req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_kind, out_handle, occupancy, zero pad
   output logic [rpcq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // status
   output logic [rpcq_pkg::STATUS_W-1:0]        rsp_tuser,
   input  logic                                 csr_wen,
   input  logic [rpcq_pkg::FREQ_W-1:0]          csr_wdata
);
   import rpcq_pkg::*;

   localparam int HANDLE_LO = KIND_W;
   localparam int SLOT_LO   = HANDLE_LO + HANDLE_W;
   localparam int TIME_LO   = SLOT_LO + SLOT_W;
   localparam int OCC_LO    = HANDLE_LO + HANDLE_W;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   logic [KIND_W-1:0]   rsp_kind;
   logic [HANDLE_W-1:0] rsp_handle;
   logic [OCC_W-1:0]    rsp_occupancy;

   rpcq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_sts     (dp_sts),
      .dp_cmd     (dp_cmd)
   );

   rpcq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .dp_sts        (dp_sts),
      .in_opcode     (req_tuser),
      .in_kind       (req_tdata[KIND_W-1:0]),
      .in_handle     (req_tdata[HANDLE_LO +: HANDLE_W]),
      .in_slot       (req_tdata[SLOT_LO +: SLOT_W]),
      .in_time       (req_tdata[TIME_LO +: TIME_W]),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_status    (rsp_tuser),
      .rsp_kind      (rsp_kind),
      .rsp_handle    (rsp_handle),
      .rsp_occupancy (rsp_occupancy)
   );

   assign rsp_tdata = {(RSP_TDATA_W - OCC_LO - OCC_W)'(0), rsp_occupancy, rsp_handle, rsp_kind};

endmodule
